[sv/shiprrip_pkg.sv]
// Shared definitions for the SHiP/SRRIP replacement unit: size defaults,
// request and reply words, sequencer states and the PC folding hash.
// No dependencies.
package shiprrip_pkg;

	localparam int unsigned NUM_SETS_DEF        = 2048;
	localparam int unsigned NUM_WAYS_DEF        = 16;
	localparam int unsigned HISTORY_ENTRIES_DEF = 2048;
	localparam int unsigned COUNTER_MAX_DEF     = 511;
	localparam int unsigned AGE_MAX_DEF         = 3;

	localparam int unsigned SET_IDX_W = 11;
	localparam int unsigned WAY_IDX_W = 4;
	localparam int unsigned PC_W      = 64;
	localparam int unsigned FOLD_W    = 32;

	typedef enum logic {
		KIND_VICTIM = 1'b0,
		KIND_UPDATE = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [SET_IDX_W-1:0] set_index;
		logic [WAY_IDX_W-1:0] way_index;
		logic [PC_W-1:0]      pc;
		logic                 was_hit;
	} req_t;

	typedef struct packed {
		logic [WAY_IDX_W-1:0] victim_way;
		kind_t                reply_kind;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP1,
		ST_PREP2,
		ST_READ,
		ST_ROW,
		ST_CTR
	} state_t;

	// xor-fold of the PC down to 32 bits, then down again within the word
	function automatic logic [FOLD_W-1:0] fold_pc(input logic [PC_W-1:0] pc);
		logic [FOLD_W-1:0] h;
		h = pc[FOLD_W-1:0] ^ pc[PC_W-1:FOLD_W];
		h = h ^ (h >> 16);
		h = h ^ (h >> 8);
		return h;
	endfunction

endpackage

[sv/shiprrip_chan_if.sv]
// Valid/ready channel carrying one word of a configurable payload type.
// Used for the request and reply channels; no dependencies.
interface shiprrip_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[sv/ship_rrip_replacement_unit.sv]
// SHiP replacement engine on RRIP.
// req carries a victim request (kind 0: set) or an update (kind 1: set, way,
// pc, was_hit); rsp returns one word per request: the victim way, or 0 for
// an update, with the kind echoed. A word moves when valid and ready are high.
// All per-line state sits in one row memory (one row per set, every way),
// the signature counters in a second memory; both have registered reads.
// A victim request or a hit reads the row, then modifies and writes it back;
// a fill adds the counter read in between. A new request is taken only in IDLE.
// When the set count is neither a power of two nor at least 2048, or the
// counter table is not a power of two, every request first passes the
// remainder steps PREP1 and PREP2, then reads its row in READ.
// Reset: the unit sweeps every row and counter address to initialize both
// memories; req.ready stays low meanwhile.
// A single reply register decouples the sides: a new request is taken while
// a reply waits, and that request then holds in its last step until the
// reply register frees.
module ship_rrip_replacement_unit #(
	parameter int unsigned NUM_SETS        = shiprrip_pkg::NUM_SETS_DEF,
	parameter int unsigned NUM_WAYS        = shiprrip_pkg::NUM_WAYS_DEF,
	parameter int unsigned HISTORY_ENTRIES = shiprrip_pkg::HISTORY_ENTRIES_DEF,
	parameter int unsigned COUNTER_MAX     = shiprrip_pkg::COUNTER_MAX_DEF,
	parameter int unsigned AGE_MAX         = shiprrip_pkg::AGE_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	shiprrip_chan_if.sink   req,
	shiprrip_chan_if.source rsp
);
	import shiprrip_pkg::*;

	localparam int unsigned RRPV_W = $clog2(AGE_MAX + 1);
	localparam int unsigned SIG_W  = $clog2(HISTORY_ENTRIES);
	localparam int unsigned CNT_W  = $clog2(COUNTER_MAX + 1);
	localparam int unsigned WAY_W  = $clog2(NUM_WAYS);
	localparam int unsigned ROW_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int unsigned CLR_N  = (NUM_SETS > HISTORY_ENTRIES) ? NUM_SETS : HISTORY_ENTRIES;
	localparam int unsigned CLR_W  = $clog2(CLR_N);

	localparam bit SET_TRIV = (NUM_SETS >= (1 << SET_IDX_W)) ||
		((NUM_SETS & (NUM_SETS - 1)) == 0);
	localparam bit SIG_POW2 = ((HISTORY_ENTRIES & (HISTORY_ENTRIES - 1)) == 0);
	localparam bit FAST     = SET_TRIV && SIG_POW2;

	localparam logic [SET_IDX_W-1:0] SET_MASK = (NUM_SETS >= (1 << SET_IDX_W)) ?
		{SET_IDX_W{1'b1}} : SET_IDX_W'(NUM_SETS - 1);

	// reciprocal constants: floor(x / d) = (x * m) >> (n + ceil(log2 d))
	localparam int unsigned SET_SH  = SET_IDX_W + $clog2(NUM_SETS);
	localparam logic [63:0] SET_M64 = (64'd1 << SET_SH) / 64'(NUM_SETS) + 64'd1;
	localparam int unsigned SET_MW  = SET_IDX_W + 1;
	localparam logic [SET_MW-1:0] SET_M = SET_M64[SET_MW-1:0];
	localparam int unsigned SET_PW  = SET_IDX_W + SET_MW;

	localparam int unsigned SIG_SH  = FOLD_W + SIG_W;
	localparam logic [63:0] SIG_M64 = (64'd1 << SIG_SH) / 64'(HISTORY_ENTRIES) + 64'd1;
	localparam int unsigned SIG_MW  = FOLD_W + 1;
	localparam logic [SIG_MW-1:0] SIG_M = SIG_M64[SIG_MW-1:0];
	localparam int unsigned SIG_PW  = FOLD_W + SIG_MW;

	typedef struct packed {
		logic              reused;
		logic [SIG_W-1:0]  sig;
		logic [RRPV_W-1:0] rrpv;
	} line_t;

	typedef line_t [NUM_WAYS-1:0] row_t;

	localparam line_t RESET_LINE = '{reused: 1'b0, sig: '0, rrpv: RRPV_W'(AGE_MAX)};
	localparam row_t  RESET_ROW  = {NUM_WAYS{RESET_LINE}};

	function automatic logic [WAY_W-1:0] way_mod(input logic [WAY_IDX_W-1:0] w);
		logic [5:0] r;
		r = 6'(w);
		for (int i = 0; i < 8; i++) begin
			if (r >= 6'(NUM_WAYS)) begin
				r = r - 6'(NUM_WAYS);
			end
		end
		return WAY_W'(r);
	endfunction

	// sequencer
	state_t state_q, state_d;
	logic [CLR_W-1:0] clr_q;
	logic clr_in_rows, clr_in_ctr;

	// request registers
	kind_t                kind_q;
	logic [SET_IDX_W-1:0] set_raw_q;
	logic [ROW_AW-1:0]    set_q;
	logic [WAY_W-1:0]     way_q;
	logic                 hit_q;
	logic [FOLD_W-1:0]    h_q;
	logic [SIG_W-1:0]     sig_q;

	// remainder pipeline
	logic [SET_PW-1:0]    setprod_s1;
	logic [SIG_PW-1:0]    hprod_s1;
	logic [SET_IDX_W-1:0] set_quo, set_rem;
	logic [FOLD_W-1:0]    sig_quo;
	logic [SIG_W-1:0]     sig_rem;

	// memories
	row_t              row_mem [NUM_SETS];
	row_t              row_rd_q;
	logic              row_ren, row_wen;
	logic [ROW_AW-1:0] row_raddr, row_waddr;
	row_t              row_wdata;

	logic [CNT_W-1:0]  ctr_mem [HISTORY_ENTRIES];
	logic [CNT_W-1:0]  ctr_rd_a_q, ctr_rd_b_q;
	logic              ctr_ren, ctr_wen;
	logic [SIG_W-1:0]  ctr_raddr_a, ctr_raddr_b, ctr_waddr;
	logic [CNT_W-1:0]  ctr_wdata;

	// row datapath
	logic [AGE_MAX:0]  lvl_any;
	logic [RRPV_W-1:0] top, age_add;
	logic [WAY_W-1:0]  victim;
	row_t              aged_row, hit_row, fill_row;
	line_t             old_line;
	logic [CNT_W-1:0]  trained, new_ctr;

	// reply register
	logic rsp_valid_q, rsp_free, rsp_load, req_fire;
	rsp_t rsp_data_q, rsp_next;

	assign req_fire    = req.valid && req.ready;
	assign rsp_free    = !rsp_valid_q || rsp.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;

	assign clr_in_rows = ({1'b0, clr_q} < (CLR_W + 1)'(NUM_SETS));
	assign clr_in_ctr  = ({1'b0, clr_q} < (CLR_W + 1)'(HISTORY_ENTRIES));

	assign set_quo = SET_IDX_W'(setprod_s1 >> SET_SH);
	assign set_rem = SET_IDX_W'(32'(set_raw_q) - 32'(set_quo) * 32'(NUM_SETS));
	assign sig_quo = FOLD_W'(hprod_s1 >> SIG_SH);
	assign sig_rem = SIG_W'(h_q - 32'(sig_quo * 32'(HISTORY_ENTRIES)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q    <= req.payload.kind;
			set_raw_q <= req.payload.set_index;
			way_q     <= way_mod(req.payload.way_index);
			hit_q     <= req.payload.was_hit;
			h_q       <= fold_pc(req.payload.pc);
			set_q     <= ROW_AW'(req.payload.set_index & SET_MASK);
			sig_q     <= SIG_W'(fold_pc(req.payload.pc));
		end else if (state_q == ST_PREP2) begin
			if (!SET_TRIV) begin
				set_q <= ROW_AW'(set_rem);
			end
			if (!SIG_POW2) begin
				sig_q <= sig_rem;
			end
		end
		setprod_s1 <= SET_PW'(set_raw_q) * SET_PW'(SET_M);
		hprod_s1   <= SIG_PW'(h_q) * SIG_PW'(SIG_M);
		if (rsp_load) begin
			rsp_data_q <= rsp_next;
		end
	end

	always_ff @(posedge clk) begin
		if (row_wen) begin
			row_mem[row_waddr] <= row_wdata;
		end
		if (row_ren) begin
			row_rd_q <= row_mem[row_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctr_wen) begin
			ctr_mem[ctr_waddr] <= ctr_wdata;
		end
		if (ctr_ren) begin
			ctr_rd_a_q <= ctr_mem[ctr_raddr_a];
			ctr_rd_b_q <= ctr_mem[ctr_raddr_b];
		end
	end

	// aging: every way rises by (AGE_MAX - top), so the ways at AGE_MAX
	// afterwards are exactly those now at top
	always_comb begin
		lvl_any = '0;
		for (int l = 0; l <= AGE_MAX; l++) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (row_rd_q[w].rrpv == RRPV_W'(l)) begin
					lvl_any[l] = 1'b1;
				end
			end
		end
		top = '0;
		for (int l = 0; l <= AGE_MAX; l++) begin
			if (lvl_any[l]) begin
				top = RRPV_W'(l);
			end
		end
		age_add = RRPV_W'(AGE_MAX) - top;

		victim = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row_rd_q[w].rrpv == top) begin
				victim = WAY_W'(w);
			end
		end

		aged_row = row_rd_q;
		for (int w = 0; w < NUM_WAYS; w++) begin
			aged_row[w].rrpv = row_rd_q[w].rrpv + age_add;
		end

		hit_row               = row_rd_q;
		hit_row[way_q].rrpv   = '0;
		hit_row[way_q].reused = 1'b1;

		// fill: train the evicted signature, then decide insertion on the
		// new one (same entry sees the trained value)
		old_line = row_rd_q[way_q];
		if (old_line.reused) begin
			trained = (ctr_rd_a_q < CNT_W'(COUNTER_MAX)) ? ctr_rd_a_q + CNT_W'(1) : ctr_rd_a_q;
		end else begin
			trained = (ctr_rd_a_q != '0) ? ctr_rd_a_q - CNT_W'(1) : ctr_rd_a_q;
		end
		new_ctr = (old_line.sig == sig_q) ? trained : ctr_rd_b_q;

		fill_row               = row_rd_q;
		fill_row[way_q].reused = 1'b0;
		fill_row[way_q].sig    = sig_q;
		fill_row[way_q].rrpv   = (new_ctr == '0) ? RRPV_W'(AGE_MAX) : '0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_W'(CLR_N - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = FAST ? ST_ROW : ST_PREP1;
				end
			end
			ST_PREP1: state_d = ST_PREP2;
			ST_PREP2: state_d = ST_READ;
			ST_READ:  state_d = ST_ROW;
			ST_ROW: begin
				if (kind_q == KIND_UPDATE && !hit_q) begin
					state_d = ST_CTR;
				end else if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_CTR: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		req.ready   = 1'b0;
		row_ren     = 1'b0;
		row_raddr   = set_q;
		row_wen     = 1'b0;
		row_waddr   = set_q;
		row_wdata   = aged_row;
		ctr_ren     = 1'b0;
		ctr_raddr_a = old_line.sig;
		ctr_raddr_b = sig_q;
		ctr_wen     = 1'b0;
		ctr_waddr   = old_line.sig;
		ctr_wdata   = trained;
		rsp_load    = 1'b0;
		rsp_next    = '{victim_way: '0, reply_kind: KIND_UPDATE};
		unique case (state_q)
			ST_CLEAR: begin
				row_wen   = clr_in_rows;
				row_waddr = ROW_AW'(clr_q);
				row_wdata = RESET_ROW;
				ctr_wen   = clr_in_ctr;
				ctr_waddr = SIG_W'(clr_q);
				ctr_wdata = CNT_W'(COUNTER_MAX);
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				row_ren   = FAST && req.valid;
				row_raddr = ROW_AW'(req.payload.set_index & SET_MASK);
			end
			ST_PREP1, ST_PREP2: begin
			end
			ST_READ: begin
				row_ren = 1'b1;
			end
			ST_ROW: begin
				if (kind_q == KIND_VICTIM) begin
					row_wen   = rsp_free;
					row_wdata = aged_row;
					rsp_load  = rsp_free;
					rsp_next  = '{victim_way: WAY_IDX_W'(victim), reply_kind: KIND_VICTIM};
				end else if (hit_q) begin
					row_wen   = rsp_free;
					row_wdata = hit_row;
					rsp_load  = rsp_free;
				end else begin
					ctr_ren = 1'b1;
				end
			end
			ST_CTR: begin
				row_wen   = rsp_free;
				row_wdata = fill_row;
				ctr_wen   = rsp_free;
				rsp_load  = rsp_free;
			end
			default: begin
			end
		endcase
	end

endmodule
